[src/prime_factorizer_core_macros.svh]
// Assertion macros for the prime factorizer core.
// Included by pfc_ctrl, which checks its own control logic.
`ifndef PRIME_FACTORIZER_CORE_MACROS_SVH
`define PRIME_FACTORIZER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfc assertion failed");

// Next-cycle implication, checked out of reset.
`define PFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfc assertion failed");

`endif

[src/pfc_pkg.sv]
// Shared widths, select codes and controller/datapath interface types
// for the prime factorizer core. No dependencies.
package pfc_pkg;

  localparam int VALUE_BITS = 31;
  localparam int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_BITS    = 2 * DIV_BITS;
  localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
  localparam int FIRST_DIV  = 3;
  localparam int DIV_STEP   = 2;

  localparam logic [1:0] SEL_TWO  = 2'd0;
  localparam logic [1:0] SEL_DIV  = 2'd1;
  localparam logic [1:0] SEL_REST = 2'd2;

  typedef struct packed {
    logic       load;
    logic       halve;
    logic       square;
    logic       div_start;
    logic       take;
    logic       next_div;
    logic       pend_load;
    logic [1:0] pend_sel;
    logic       out_load;
    logic       out_zero;
    logic       out_last;
    logic       out_nf;
  } cmd_t;

  typedef struct packed {
    logic rest_lt2;
    logic rest_gt2;
    logic rest_even;
    logic sq_gt;
    logic div_done;
    logic rem_zero;
  } stat_t;

endpackage

[src/pfc_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on pfc_pkg for widths.
module pfc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [pfc_pkg::VALUE_BITS-1:0]   dividend,
  input  logic [pfc_pkg::DIV_BITS-1:0]     divisor,
  output logic                             done,
  output logic [pfc_pkg::VALUE_BITS-1:0]   quotient,
  output logic                             rem_zero
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [pfc_pkg::CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic [pfc_pkg::VALUE_BITS-1:0]  quo_r, quo_nxt;
  logic [pfc_pkg::DIV_BITS:0]      rem_r, rem_nxt;
  logic [pfc_pkg::DIV_BITS-1:0]    dvs_r, dvs_nxt;
  logic [pfc_pkg::DIV_BITS:0]      rem_sh;
  logic                            ge;

  assign rem_sh = {rem_r[pfc_pkg::DIV_BITS-1:0], quo_r[pfc_pkg::VALUE_BITS-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = pfc_pkg::CNT_BITS'(pfc_pkg::VALUE_BITS);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[pfc_pkg::VALUE_BITS-2:0], ge};
      rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      cnt_nxt = cnt_r - pfc_pkg::CNT_BITS'(1);
      if (cnt_r == pfc_pkg::CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
  assign rem_zero = (rem_r == '0);

endmodule

[src/pfc_dpath.sv]
// Datapath: remaining value, trial divisor, its square, pending factor
// and result registers. Depends on pfc_pkg and pfc_div.
module pfc_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pfc_pkg::cmd_t                   cmd,
  output pfc_pkg::stat_t                  stat,
  input  logic [pfc_pkg::VALUE_BITS-1:0]  in_value,
  output logic [pfc_pkg::VALUE_BITS-1:0]  out_factor,
  output logic                            out_last,
  output logic                            out_no_factors
);

  logic [pfc_pkg::VALUE_BITS-1:0] rest_r, rest_nxt;
  logic [pfc_pkg::DIV_BITS-1:0]   d_r, d_nxt;
  logic [pfc_pkg::SQ_BITS-1:0]    sq_r, sq_nxt;
  logic [pfc_pkg::VALUE_BITS-1:0] pend_r, pend_nxt;
  logic [pfc_pkg::VALUE_BITS-1:0] ofac_r, ofac_nxt;
  logic                           olast_r, olast_nxt;
  logic                           onf_r, onf_nxt;
  logic                           div_done;
  logic                           rem_zero;
  logic [pfc_pkg::VALUE_BITS-1:0] quotient;

  pfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rest_r),
    .divisor  (d_r),
    .done     (div_done),
    .quotient (quotient),
    .rem_zero (rem_zero)
  );

  always_comb begin
    rest_nxt = rest_r;
    d_nxt    = d_r;
    sq_nxt   = sq_r;
    pend_nxt = pend_r;
    if (cmd.load) begin
      rest_nxt = in_value;
      d_nxt    = pfc_pkg::DIV_BITS'(pfc_pkg::FIRST_DIV);
    end else if (cmd.halve) begin
      rest_nxt = rest_r >> 1;
    end else if (cmd.take) begin
      rest_nxt = quotient;
    end
    if (cmd.next_div) begin
      d_nxt = d_r + pfc_pkg::DIV_BITS'(pfc_pkg::DIV_STEP);
    end
    if (cmd.square) begin
      sq_nxt = pfc_pkg::SQ_BITS'(d_r) * pfc_pkg::SQ_BITS'(d_r);
    end
    if (cmd.pend_load) begin
      case (cmd.pend_sel)
        pfc_pkg::SEL_TWO:  pend_nxt = pfc_pkg::VALUE_BITS'(2);
        pfc_pkg::SEL_DIV:  pend_nxt = pfc_pkg::VALUE_BITS'(d_r);
        pfc_pkg::SEL_REST: pend_nxt = rest_r;
        default:           pend_nxt = pend_r;
      endcase
    end
  end

  always_comb begin
    ofac_nxt  = ofac_r;
    olast_nxt = olast_r;
    onf_nxt   = onf_r;
    if (cmd.out_load) begin
      ofac_nxt  = cmd.out_zero ? '0 : pend_r;
      olast_nxt = cmd.out_last;
      onf_nxt   = cmd.out_nf;
    end
  end

  always_ff @(posedge clk) begin
    rest_r  <= rest_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    pend_r  <= pend_nxt;
    ofac_r  <= ofac_nxt;
    olast_r <= olast_nxt;
    onf_r   <= onf_nxt;
  end

  assign stat.rest_lt2  = rest_r < pfc_pkg::VALUE_BITS'(2);
  assign stat.rest_gt2  = rest_r > pfc_pkg::VALUE_BITS'(2);
  assign stat.rest_even = ~rest_r[0];
  assign stat.sq_gt     = sq_r > pfc_pkg::SQ_BITS'(rest_r);
  assign stat.div_done  = div_done;
  assign stat.rem_zero  = rem_zero;

  assign out_factor     = ofac_r;
  assign out_last       = olast_r;
  assign out_no_factors = onf_r;

endmodule

[src/pfc_ctrl.sv]
// Controller: sequences trial division, holds one pending factor so the
// final one can be marked, and drives the handshakes. Depends on pfc_pkg and the macros header.
`include "prime_factorizer_core_macros.svh"

module pfc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pfc_pkg::stat_t stat,
  output pfc_pkg::cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_TWOS = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;
  localparam logic [2:0] ST_LAST = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       pend_vld_r, pend_vld_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       found;
  logic       can_take;

  assign out_free = !out_valid_r || out_ready;
  assign can_take = !pend_vld_r || out_free;

  always_comb begin
    state_nxt    = state_r;
    pend_vld_nxt = pend_vld_r;
    cmd          = '0;
    found        = 1'b0;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (stat.rest_lt2) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_zero = 1'b1;
            cmd.out_last = 1'b1;
            cmd.out_nf   = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else begin
          state_nxt = ST_TWOS;
        end
      end
      ST_TWOS: begin
        if (stat.rest_even) begin
          found        = 1'b1;
          cmd.pend_sel = pfc_pkg::SEL_TWO;
          cmd.halve    = can_take;
        end else begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = ST_CMP;
      end
      ST_CMP: begin
        if (stat.sq_gt) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          if (stat.rem_zero) begin
            found        = 1'b1;
            cmd.pend_sel = pfc_pkg::SEL_DIV;
            cmd.take     = can_take;
            if (can_take) begin
              state_nxt = ST_CMP;
            end
          end else begin
            cmd.next_div = 1'b1;
            state_nxt    = ST_SQ;
          end
        end
      end
      ST_FIN: begin
        if (stat.rest_gt2) begin
          found        = 1'b1;
          cmd.pend_sel = pfc_pkg::SEL_REST;
          if (can_take) begin
            state_nxt = ST_LAST;
          end
        end else begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (found && can_take) begin
      cmd.pend_load = 1'b1;
      cmd.out_load  = pend_vld_r;
      pend_vld_nxt  = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `PFC_ASSERT_IMP(a_out_slot_free, clk, rst_n, cmd.out_load, !out_valid_r || out_ready)
  `PFC_ASSERT_IMP(a_idle_no_pend, clk, rst_n, state_r == ST_IDLE, !pend_vld_r)
  `PFC_ASSERT_IMP(a_last_has_pend, clk, rst_n, state_r == ST_LAST, pend_vld_r)
  `PFC_ASSERT_NXT(a_div_restart, clk, rst_n, cmd.div_start, !stat.div_done)

endmodule

[src/prime_factorizer_core.sv]
// Prime factorizer by trial division: strips twos, then tries odd divisors.
// Odd trial divisors run through the bit-serial divider until the square of
// the divisor exceeds the rest. Throughput: one item at a time; the next
// item is taken once the last factor sits in the output register. Synchronous
// active-low reset clears control state only; no memory is cleared.
module prime_factorizer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pfc_pkg::VALUE_BITS-1:0]  in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pfc_pkg::VALUE_BITS-1:0]  out_factor,
  output logic                            out_last,
  output logic                            out_no_factors
);

  pfc_pkg::cmd_t  cmd;
  pfc_pkg::stat_t stat;

  pfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfc_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_value       (in_value),
    .out_factor     (out_factor),
    .out_last       (out_last),
    .out_no_factors (out_no_factors)
  );

endmodule
